### hw/rtl/ffha_pkg.sv
package ffha_pkg;

    // request kind carried on the input tuser
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ALLOC_OK   = 3'd0;
    localparam logic [2:0] ST_ALLOC_FAIL = 3'd1;
    localparam logic [2:0] ST_FREED      = 3'd2;
    localparam logic [2:0] ST_NULL       = 3'd3;
    localparam logic [2:0] ST_OUTSIDE    = 3'd4;
    localparam logic [2:0] ST_DOUBLE     = 3'd5;

    localparam int GRAN_SHIFT = 4;   // 16-byte granules
    localparam int BYTE_W     = 20;  // byte offsets and sizes
    localparam int STATUS_W   = 3;

endpackage

### hw/rtl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/first_fit_heap_allocator_unit.sv
// path to the output register: null, outside-arena and refused sizes go straight to push,
// a free checks and rewrites its header first, an allocation walks, merges and marks a block
// throughput: one item at a time, the next accepted in the cycle after its result is loaded;
// the walk reads one header at a time on the single read port, a held result stalls the push
// reset: synchronous, active low; after reset the init state writes header 0 as a free
// block spanning the whole arena, no item is accepted in that state
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int ARENA_GRANULES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // request_bytes[19:0], free_offset[39:20]
    input  logic        s_axis_tuser,   // func: 0 allocate, 1 free
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // data_offset[19:0], zero fill[23:20]
    output logic [2:0]  m_axis_tuser    // status
);

    // granule index width; header size field holds up to ARENA_GRANULES - 1
    localparam int GW = (ARENA_GRANULES > 1) ? $clog2(ARENA_GRANULES) : 1;
    localparam int HW = GW + 1;  // header: {free, size}
    localparam logic [GW:0]     ARENA_G     = (GW + 1)'(ARENA_GRANULES);
    localparam logic [BYTE_W:0] ARENA_BYTES = (BYTE_W + 1)'(ARENA_GRANULES * 16);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FREE_CHK,
        S_A_LOAD,
        S_A_EVAL,
        S_A_NXT,
        S_A_WCUR,
        S_PUSH
    } t_state;

    t_state r_state, n_state;

    // block under inspection
    logic [GW-1:0]       r_cur, n_cur;
    logic [GW-1:0]       r_nxt, n_nxt;
    logic                r_hdr_free, n_hdr_free;
    logic [GW-1:0]       r_hdr_size, n_hdr_size;
    logic [GW:0]         r_need, n_need;
    // pending result
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [BYTE_W-1:0]   r_res_offset, n_res_offset;
    // output register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [BYTE_W-1:0]   r_out_offset, n_out_offset;

    // header memory ports
    logic          ram_we;
    logic [GW-1:0] ram_waddr;
    logic [HW-1:0] ram_wdata;
    logic [GW-1:0] ram_raddr;
    logic [HW-1:0] ram_rdata;

    ffha_ram #(
        .WIDTH(HW),
        .DEPTH(ARENA_GRANULES)
    ) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // request fields
    logic [BYTE_W-1:0] req_bytes;
    logic [BYTE_W-1:0] free_off;
    assign req_bytes = s_axis_tdata[19:0];
    assign free_off  = s_axis_tdata[39:20];

    // header read back from memory
    logic          rd_free;
    logic [GW-1:0] rd_size;
    assign rd_free = ram_rdata[GW];
    assign rd_size = ram_rdata[GW-1:0];

    // walk arithmetic, all on GW+1 bits so the arena end never wraps
    logic [GW:0] size_ext;
    logic [GW:0] nxt_w;
    logic [GW:0] spare_w;
    logic [GW:0] merged_w;
    logic        fits;
    logic        do_split;
    assign size_ext = {1'b0, r_hdr_size};
    assign nxt_w    = {1'b0, r_cur} + (GW + 1)'(1) + size_ext;
    assign spare_w  = {1'b0, r_cur} + (GW + 1)'(1) + r_need;
    assign merged_w = size_ext + (GW + 1)'(1) + {1'b0, rd_size};
    assign fits     = r_hdr_free && (size_ext >= r_need);
    assign do_split = (size_ext > r_need + (GW + 1)'(1)) && (spare_w < ARENA_G);

    // request decode
    logic [BYTE_W:0] bytes_rnd;
    logic [GW-1:0]   free_idx;
    assign bytes_rnd = {1'b0, req_bytes} + (BYTE_W + 1)'(15);
    assign free_idx  = GW'(free_off[BYTE_W-1:GRAN_SHIFT] - 16'd1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'd0, r_out_offset};

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_hdr_free   = r_hdr_free;
        n_hdr_size   = r_hdr_size;
        n_need       = r_need;
        n_res_status = r_res_status;
        n_res_offset = r_res_offset;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_offset = r_out_offset;
        ram_we       = 1'b0;
        ram_waddr    = r_cur;
        ram_wdata    = {r_hdr_free, r_hdr_size};
        ram_raddr    = r_cur;

        // result taken downstream
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                // whole arena as one free block
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {1'b1, GW'(ARENA_GRANULES - 1)};
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_offset = '0;
                    if (s_axis_tuser == FUNC_FREE) begin
                        if (free_off == '0) begin
                            n_res_status = ST_NULL;
                            n_state      = S_PUSH;
                        end else if (({1'b0, free_off} >= ARENA_BYTES) ||
                                     (free_off[BYTE_W-1:GRAN_SHIFT] == '0)) begin
                            n_res_status = ST_OUTSIDE;
                            n_state      = S_PUSH;
                        end else begin
                            ram_raddr = free_idx;
                            n_cur     = free_idx;
                            n_state   = S_FREE_CHK;
                        end
                    end else begin
                        if ((req_bytes == '0) || ({1'b0, req_bytes} >= ARENA_BYTES)) begin
                            n_res_status = ST_ALLOC_FAIL;
                            n_state      = S_PUSH;
                        end else begin
                            n_need    = (GW + 1)'(bytes_rnd >> GRAN_SHIFT);
                            ram_raddr = '0;
                            n_cur     = '0;
                            n_state   = S_A_LOAD;
                        end
                    end
                end
            end
            S_FREE_CHK: begin
                if (rd_free) begin
                    n_res_status = ST_DOUBLE;
                end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_cur;
                    ram_wdata    = {1'b1, rd_size};
                    n_res_status = ST_FREED;
                end
                n_state = S_PUSH;
            end
            S_A_LOAD: begin
                n_hdr_free = rd_free;
                n_hdr_size = rd_size;
                n_state    = S_A_EVAL;
            end
            S_A_EVAL: begin
                if (fits) begin
                    if (do_split) begin
                        // carve the tail into a new free block
                        ram_we     = 1'b1;
                        ram_waddr  = spare_w[GW-1:0];
                        ram_wdata  = {1'b1, GW'(size_ext - r_need - (GW + 1)'(1))};
                        n_hdr_size = r_need[GW-1:0];
                    end
                    n_state = S_A_WCUR;
                end else if (nxt_w >= ARENA_G) begin
                    // walked off the arena end, merges already written stay
                    n_res_status = ST_ALLOC_FAIL;
                    n_state      = S_PUSH;
                end else begin
                    ram_raddr = nxt_w[GW-1:0];
                    n_nxt     = nxt_w[GW-1:0];
                    n_state   = S_A_NXT;
                end
            end
            S_A_NXT: begin
                if (r_hdr_free && rd_free) begin
                    // lazy coalescing of two neighboring free blocks
                    n_hdr_size = merged_w[GW-1:0];
                    ram_we     = 1'b1;
                    ram_waddr  = r_cur;
                    ram_wdata  = {1'b1, merged_w[GW-1:0]};
                end else begin
                    n_cur      = r_nxt;
                    n_hdr_free = rd_free;
                    n_hdr_size = rd_size;
                end
                n_state = S_A_EVAL;
            end
            S_A_WCUR: begin
                ram_we       = 1'b1;
                ram_waddr    = r_cur;
                ram_wdata    = {1'b0, r_hdr_size};
                n_hdr_free   = 1'b0;
                n_res_status = ST_ALLOC_OK;
                n_res_offset = BYTE_W'(({{(32 - GW){1'b0}}, r_cur} + 32'd1) << GRAN_SHIFT);
                n_state      = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_offset = r_res_offset;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cur        <= n_cur;
        r_nxt        <= n_nxt;
        r_hdr_free   <= n_hdr_free;
        r_hdr_size   <= n_hdr_size;
        r_need       <= n_need;
        r_res_status <= n_res_status;
        r_res_offset <= n_res_offset;
        r_out_status <= n_out_status;
        r_out_offset <= n_out_offset;
    end

endmodule
